[design/pqe_pkg.sv]
package pqe_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W   = 32;
  localparam int IDX_W     = 24;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LOOP = 1'b1;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 32'h0001_0000;

  typedef enum logic [2:0] {
    REC_VERTEX = 3'd0,
    REC_TRI    = 3'd1,
    REC_BMIN   = 3'd2,
    REC_BMAX   = 3'd3,
    REC_EMPTY  = 3'd4
  } rec_kind_t;

  typedef enum logic {
    JOB_SEG = 1'b0,
    JOB_FIN = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic signed [COORD_W-1:0]  x0;
    logic signed [COORD_W-1:0]  y0;
    logic signed [COORD_W-1:0]  z0;
    logic signed [COORD_W-1:0]  x1;
    logic signed [COORD_W-1:0]  y1;
    logic signed [COORD_W-1:0]  z1;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEG,
    F_CLOSE,
    F_FIN
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_CHECK,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_MUL,
    B_DINIT,
    B_DIV,
    B_OFS,
    B_V0,
    B_V1,
    B_V2,
    B_V3,
    B_T0,
    B_T1,
    B_FIN,
    B_BMAX
  } back_state_t;

endpackage

[design/pqe_ifs.sv]
interface pqe_pt_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pqe_pkg::COORD_W-1:0]   point_x;
  logic signed [pqe_pkg::COORD_W-1:0]   point_y;
  logic signed [pqe_pkg::COORD_W-1:0]   point_z;
  logic                                 end_of_line;

  modport source (output valid, point_x, point_y, point_z, end_of_line, input ready);
  modport sink   (input valid, point_x, point_y, point_z, end_of_line, output ready);
endinterface

interface pqe_rec_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           record_kind;
  logic signed [pqe_pkg::COORD_W-1:0]   pos_x;
  logic signed [pqe_pkg::COORD_W-1:0]   pos_y;
  logic signed [pqe_pkg::COORD_W-1:0]   pos_z;
  logic [1:0]                           corner;
  logic [pqe_pkg::IDX_W-1:0]            index_a;
  logic [pqe_pkg::IDX_W-1:0]            index_b;
  logic [pqe_pkg::IDX_W-1:0]            index_c;
  logic                                 last_record;

  modport source (output valid, record_kind, pos_x, pos_y, pos_z, corner,
                  index_a, index_b, index_c, last_record, input ready);
  modport sink   (input valid, record_kind, pos_x, pos_y, pos_z, corner,
                  index_a, index_b, index_c, last_record, output ready);
endinterface

[design/pqe_front.sv]
module pqe_front (
  input  logic            clk,
  input  logic            rst,
  pqe_pt_if.sink          pt,
  input  logic            closed_loop,
  output pqe_pkg::job_t   push_job,
  output logic            push_valid,
  input  logic            push_ready
);

  pqe_pkg::front_state_t state, state_next;

  logic signed [pqe_pkg::COORD_W-1:0] first_x, first_y, first_z;
  logic signed [pqe_pkg::COORD_W-1:0] prev_x, prev_y, prev_z;
  logic signed [pqe_pkg::COORD_W-1:0] seg_x, seg_y, seg_z;
  logic have_prev;
  logic eol_r;
  logic close_r;
  logic accept;

  assign pt.ready = (state == pqe_pkg::F_IDLE);
  assign accept   = pt.valid && pt.ready;

  always_comb begin
    state_next = state;
    case (state)
      pqe_pkg::F_IDLE: begin
        if (accept) begin
          if (have_prev) state_next = pqe_pkg::F_SEG;
          else if (pt.end_of_line)
            state_next = closed_loop ? pqe_pkg::F_CLOSE : pqe_pkg::F_FIN;
        end
      end
      pqe_pkg::F_SEG: begin
        if (push_ready) begin
          if (!eol_r) state_next = pqe_pkg::F_IDLE;
          else state_next = close_r ? pqe_pkg::F_CLOSE : pqe_pkg::F_FIN;
        end
      end
      pqe_pkg::F_CLOSE: if (push_ready) state_next = pqe_pkg::F_FIN;
      pqe_pkg::F_FIN:   if (push_ready) state_next = pqe_pkg::F_IDLE;
      default:          state_next = pqe_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    push_valid = (state != pqe_pkg::F_IDLE);
    push_job   = '0;
    case (state)
      pqe_pkg::F_SEG: begin
        push_job.kind = pqe_pkg::JOB_SEG;
        push_job.x0 = seg_x;  push_job.y0 = seg_y;  push_job.z0 = seg_z;
        push_job.x1 = prev_x; push_job.y1 = prev_y; push_job.z1 = prev_z;
      end
      pqe_pkg::F_CLOSE: begin
        push_job.kind = pqe_pkg::JOB_SEG;
        push_job.x0 = prev_x;  push_job.y0 = prev_y;  push_job.z0 = prev_z;
        push_job.x1 = first_x; push_job.y1 = first_y; push_job.z1 = first_z;
      end
      pqe_pkg::F_FIN: push_job.kind = pqe_pkg::JOB_FIN;
      default: push_job = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pqe_pkg::F_IDLE;
      have_prev <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) have_prev <= !pt.end_of_line;
    end
    if (accept) begin
      seg_x   <= prev_x;
      seg_y   <= prev_y;
      seg_z   <= prev_z;
      prev_x  <= pt.point_x;
      prev_y  <= pt.point_y;
      prev_z  <= pt.point_z;
      eol_r   <= pt.end_of_line;
      close_r <= closed_loop;
      if (!have_prev) begin
        first_x <= pt.point_x;
        first_y <= pt.point_y;
        first_z <= pt.point_z;
      end
    end
  end

endmodule

[design/pqe_queue.sv]
module pqe_queue (
  input  logic            clk,
  input  logic            rst,
  input  pqe_pkg::job_t   push_job,
  input  logic            push,
  output logic            push_ready,
  output pqe_pkg::job_t   head_job,
  output logic            head_valid,
  input  logic            pop
);

  pqe_pkg::job_t mem [pqe_pkg::QDEPTH];
  logic [pqe_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [pqe_pkg::QPTR_W:0]   count;

  assign push_ready = (count != (pqe_pkg::QPTR_W+1)'(pqe_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) mem[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> push_ready)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job popped from empty queue");

endmodule

[design/pqe_back.sv]
module pqe_back #(
  parameter int INDEX_BITS = pqe_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = pqe_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pqe_pkg::job_t               job,
  input  logic                        job_valid,
  output logic                        job_pop,
  input  logic [pqe_pkg::CFG_W-1:0]   line_width,
  pqe_rec_if.source                   rec
);

  localparam logic [63:0] DEG_MAX =
    ((64'd1 << (2*FRAC_BITS)) - 64'd1) / 64'd1000000000000;
  localparam logic [INDEX_BITS:0] VC_LIMIT = {1'b0, {INDEX_BITS{1'b1}}};
  localparam logic [INDEX_BITS:0] QUAD = (INDEX_BITS+1)'(4);
  localparam int XW = INDEX_BITS + pqe_pkg::IDX_W;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -35'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [pqe_pkg::IDX_W-1:0] idx_out(input logic [INDEX_BITS-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[pqe_pkg::IDX_W-1:0];
  endfunction

  pqe_pkg::back_state_t state, state_next;

  logic signed [31:0] p0x, p0y, p0z, p1x, p1y, p1z;
  logic [32:0] ax, ay, az;
  logic dx_neg, dy_neg;
  logic [1:0]  sq_cnt;
  logic [63:0] acc, sq_rem, root, sq_bit;
  logic        div_y;
  logic [62:0] prod;
  logic [31:0] num_lo, quo, mx, my;
  logic [33:0] drem;
  logic [4:0]  dcnt;
  logic signed [33:0] ox, oy;
  logic [INDEX_BITS-1:0] vc;
  logic signed [31:0] bmin_x, bmin_y, bmin_z, bmax_x, bmax_y, bmax_z;

  // output register
  logic        out_valid;
  logic [2:0]  o_kind;
  logic signed [31:0] o_x, o_y, o_z;
  logic [1:0]  o_corner;
  logic [pqe_pkg::IDX_W-1:0] o_a, o_b, o_c;
  logic        o_last;

  logic [2:0]  n_kind;
  logic signed [31:0] n_x, n_y, n_z;
  logic [1:0]  n_corner;
  logic [pqe_pkg::IDX_W-1:0] n_a, n_b, n_c;
  logic        n_last;
  logic        rec_load;
  logic        ld;

  // segment arithmetic
  logic signed [32:0] dx, dy, dz;
  logic [32:0] m;
  logic [17:0] s8;
  logic degen, cnt_full, in_range;
  logic [30:0] sq_sel;
  logic [63:0] sq_sum, sq_try;
  logic [63:0] num;
  logic [33:0] div_t, div_den;
  logic        div_ge;
  logic signed [31:0] vb_x, vb_y, vb_z;
  logic        v_plus;
  logic signed [34:0] vx, vy;

  assign ld = !out_valid || rec.ready;

  assign dx = 33'(job.x1) - 33'(job.x0);
  assign dy = 33'(job.y1) - 33'(job.y0);
  assign dz = 33'(job.z1) - 33'(job.z0);

  always_comb begin
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
  end

  assign s8 = 18'(ax[7:0] * ax[7:0]) + 18'(ay[7:0] * ay[7:0]) + 18'(az[7:0] * az[7:0]);
  assign degen    = (m < 33'd256) && ({46'd0, s8} <= DEG_MAX);
  assign cnt_full = ({1'b0, vc} + QUAD) > VC_LIMIT;
  assign in_range = (m[32:31] == 2'b00) && (m[30:29] != 2'b00);

  always_comb begin
    case (sq_cnt)
      2'd0:    sq_sel = ax[30:0];
      2'd1:    sq_sel = ay[30:0];
      default: sq_sel = az[30:0];
    endcase
  end
  assign sq_sum = acc + 64'(sq_sel * sq_sel);
  assign sq_try = root + sq_bit;

  assign num     = {1'b0, prod} + {32'd0, root[31:0]};
  assign div_den = {1'b0, root[31:0], 1'b0};
  assign div_t   = {drem[32:0], num_lo[31]};
  assign div_ge  = div_t >= div_den;

  // corner selection: 0 = p0 - off, 1 = p0 + off, 2 = p1 + off, 3 = p1 - off
  always_comb begin
    if (state == pqe_pkg::B_V0 || state == pqe_pkg::B_V1) begin
      vb_x = p0x; vb_y = p0y; vb_z = p0z;
    end else begin
      vb_x = p1x; vb_y = p1y; vb_z = p1z;
    end
    v_plus = (state == pqe_pkg::B_V1 || state == pqe_pkg::B_V2);
    vx = v_plus ? 35'(vb_x) + 35'(ox) : 35'(vb_x) - 35'(ox);
    vy = v_plus ? 35'(vb_y) + 35'(oy) : 35'(vb_y) - 35'(oy);
  end

  always_comb begin
    state_next = state;
    case (state)
      pqe_pkg::B_IDLE: begin
        if (job_valid)
          state_next = (job.kind == pqe_pkg::JOB_FIN) ? pqe_pkg::B_FIN : pqe_pkg::B_CHECK;
      end
      pqe_pkg::B_CHECK: state_next = (degen || cnt_full) ? pqe_pkg::B_IDLE : pqe_pkg::B_NORM;
      pqe_pkg::B_NORM:  if (in_range) state_next = pqe_pkg::B_SQ;
      pqe_pkg::B_SQ:    if (sq_cnt == 2'd2) state_next = pqe_pkg::B_SQRT;
      pqe_pkg::B_SQRT:  if (sq_bit[0]) state_next = pqe_pkg::B_MUL;
      pqe_pkg::B_MUL:   state_next = pqe_pkg::B_DINIT;
      pqe_pkg::B_DINIT: state_next = pqe_pkg::B_DIV;
      pqe_pkg::B_DIV: begin
        if (dcnt == 5'd31) state_next = div_y ? pqe_pkg::B_OFS : pqe_pkg::B_MUL;
      end
      pqe_pkg::B_OFS:   state_next = pqe_pkg::B_V0;
      pqe_pkg::B_V0:    if (ld) state_next = pqe_pkg::B_V1;
      pqe_pkg::B_V1:    if (ld) state_next = pqe_pkg::B_V2;
      pqe_pkg::B_V2:    if (ld) state_next = pqe_pkg::B_V3;
      pqe_pkg::B_V3:    if (ld) state_next = pqe_pkg::B_T0;
      pqe_pkg::B_T0:    if (ld) state_next = pqe_pkg::B_T1;
      pqe_pkg::B_T1:    if (ld) state_next = pqe_pkg::B_IDLE;
      pqe_pkg::B_FIN: begin
        if (ld) state_next = (vc == '0) ? pqe_pkg::B_IDLE : pqe_pkg::B_BMAX;
      end
      pqe_pkg::B_BMAX:  if (ld) state_next = pqe_pkg::B_IDLE;
      default:          state_next = pqe_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (state == pqe_pkg::B_IDLE) && job_valid;
    rec_load = 1'b0;
    n_kind   = pqe_pkg::REC_VERTEX;
    n_x = '0; n_y = '0; n_z = '0;
    n_corner = '0;
    n_a = '0; n_b = '0; n_c = '0;
    n_last = 1'b0;
    case (state)
      pqe_pkg::B_V0, pqe_pkg::B_V1, pqe_pkg::B_V2, pqe_pkg::B_V3: begin
        rec_load = ld;
        n_x = sat32(vx);
        n_y = sat32(vy);
        n_z = vb_z;
        case (state)
          pqe_pkg::B_V1: n_corner = 2'd1;
          pqe_pkg::B_V2: n_corner = 2'd2;
          pqe_pkg::B_V3: n_corner = 2'd3;
          default:       n_corner = 2'd0;
        endcase
      end
      pqe_pkg::B_T0: begin
        rec_load = ld;
        n_kind = pqe_pkg::REC_TRI;
        n_a = idx_out(vc);
        n_b = idx_out(vc + INDEX_BITS'(1));
        n_c = idx_out(vc + INDEX_BITS'(2));
      end
      pqe_pkg::B_T1: begin
        rec_load = ld;
        n_kind = pqe_pkg::REC_TRI;
        n_a = idx_out(vc);
        n_b = idx_out(vc + INDEX_BITS'(2));
        n_c = idx_out(vc + INDEX_BITS'(3));
      end
      pqe_pkg::B_FIN: begin
        rec_load = ld;
        if (vc == '0) begin
          n_kind = pqe_pkg::REC_EMPTY;
          n_last = 1'b1;
        end else begin
          n_kind = pqe_pkg::REC_BMIN;
          n_x = bmin_x; n_y = bmin_y; n_z = bmin_z;
        end
      end
      pqe_pkg::B_BMAX: begin
        rec_load = ld;
        n_kind = pqe_pkg::REC_BMAX;
        n_x = bmax_x; n_y = bmax_y; n_z = bmax_z;
        n_last = 1'b1;
      end
      default: rec_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pqe_pkg::B_IDLE;
      out_valid <= 1'b0;
      vc        <= '0;
      bmin_x <= 32'sh7FFF_FFFF; bmin_y <= 32'sh7FFF_FFFF; bmin_z <= 32'sh7FFF_FFFF;
      bmax_x <= 32'sh8000_0000; bmax_y <= 32'sh8000_0000; bmax_z <= 32'sh8000_0000;
    end else begin
      state <= state_next;
      if (rec_load) out_valid <= 1'b1;
      else if (rec.ready) out_valid <= 1'b0;
      if (rec_load && (state == pqe_pkg::B_V0 || state == pqe_pkg::B_V1 ||
                       state == pqe_pkg::B_V2 || state == pqe_pkg::B_V3)) begin
        if (n_x < bmin_x) bmin_x <= n_x;
        if (n_y < bmin_y) bmin_y <= n_y;
        if (n_z < bmin_z) bmin_z <= n_z;
        if (n_x > bmax_x) bmax_x <= n_x;
        if (n_y > bmax_y) bmax_y <= n_y;
        if (n_z > bmax_z) bmax_z <= n_z;
      end
      if (rec_load && state == pqe_pkg::B_T1) vc <= vc + INDEX_BITS'(4);
      if (rec_load && n_last) begin
        vc <= '0;
        bmin_x <= 32'sh7FFF_FFFF; bmin_y <= 32'sh7FFF_FFFF; bmin_z <= 32'sh7FFF_FFFF;
        bmax_x <= 32'sh8000_0000; bmax_y <= 32'sh8000_0000; bmax_z <= 32'sh8000_0000;
      end
    end

    if (rec_load) begin
      o_kind <= n_kind; o_x <= n_x; o_y <= n_y; o_z <= n_z;
      o_corner <= n_corner; o_a <= n_a; o_b <= n_b; o_c <= n_c;
      o_last <= n_last;
    end

    case (state)
      pqe_pkg::B_IDLE: begin
        p0x <= job.x0; p0y <= job.y0; p0z <= job.z0;
        p1x <= job.x1; p1y <= job.y1; p1z <= job.z1;
        ax <= dx[32] ? 33'(-dx) : 33'(dx);
        ay <= dy[32] ? 33'(-dy) : 33'(dy);
        az <= dz[32] ? 33'(-dz) : 33'(dz);
        dx_neg <= dx[32];
        dy_neg <= dy[32];
      end
      pqe_pkg::B_NORM: begin
        sq_cnt <= '0;
        acc    <= '0;
        div_y  <= 1'b0;
        if (m[32:31] != 2'b00) begin
          ax <= ax >> 1; ay <= ay >> 1; az <= az >> 1;
        end else if (m[30:25] == 6'd0) begin
          ax <= ax << 4; ay <= ay << 4; az <= az << 4;
        end else if (!in_range) begin
          ax <= ax << 1; ay <= ay << 1; az <= az << 1;
        end
      end
      pqe_pkg::B_SQ: begin
        acc    <= sq_sum;
        sq_cnt <= sq_cnt + 2'd1;
        sq_rem <= sq_sum;
        root   <= '0;
        sq_bit <= 64'd1 << 62;
      end
      pqe_pkg::B_SQRT: begin
        if (sq_rem >= sq_try) begin
          sq_rem <= sq_rem - sq_try;
          root   <= (root >> 1) + sq_bit;
        end else begin
          root <= root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      pqe_pkg::B_MUL: prod <= 63'(line_width * (div_y ? ax[30:0] : ay[30:0]));
      pqe_pkg::B_DINIT: begin
        drem   <= {2'b00, num[63:32]};
        num_lo <= num[31:0];
        quo    <= '0;
        dcnt   <= '0;
      end
      pqe_pkg::B_DIV: begin
        drem   <= div_ge ? div_t - div_den : div_t;
        quo    <= {quo[30:0], div_ge};
        num_lo <= num_lo << 1;
        dcnt   <= dcnt + 5'd1;
        if (dcnt == 5'd31) begin
          if (div_y) my <= {quo[30:0], div_ge};
          else mx <= {quo[30:0], div_ge};
          div_y <= 1'b1;
        end
      end
      pqe_pkg::B_OFS: begin
        ox <= dy_neg ? $signed({2'b00, mx}) : -$signed({2'b00, mx});
        oy <= dx_neg ? -$signed({2'b00, my}) : $signed({2'b00, my});
      end
      default: ;
    endcase
  end

  assign rec.valid       = out_valid;
  assign rec.record_kind = o_kind;
  assign rec.pos_x       = o_x;
  assign rec.pos_y       = o_y;
  assign rec.pos_z       = o_z;
  assign rec.corner      = o_corner;
  assign rec.index_a     = o_a;
  assign rec.index_b     = o_b;
  assign rec.index_c     = o_c;
  assign rec.last_record = o_last;

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_last) |->
      (o_kind == pqe_pkg::REC_BMAX || o_kind == pqe_pkg::REC_EMPTY))
    else $error("last record on a non-closing kind");
  a_len_norm: assert property (@(posedge clk) disable iff (rst)
    (state == pqe_pkg::B_DIV) |-> (root[31:29] != 3'd0))
    else $error("segment length below normalized range");
  a_quad_step: assert property (@(posedge clk) disable iff (rst)
    (rec_load && state == pqe_pkg::B_T1) |=> (vc[1:0] == 2'b00))
    else $error("vertex count not a whole number of quads");

endmodule

[design/polyline_quad_expander.sv]
// Thick-line mesh generator: points arrive one transaction at a time on pt
// (signed Q16.16); for every non-degenerate segment that still fits in the
// vertex index space the block returns four corner vertex records and two
// triangle records on rec, and on the point marked end_of_line an optional
// closing segment, then the bounding box (minimum, maximum) or a single
// empty-mesh record. Write line_width and closed_loop through the cfg port
// only while no point is in flight. A front stage takes points and turns
// them into segment and finish jobs, a four-entry job queue decouples it
// from the back stage, which runs each segment through an iterative
// normalize, a sum of squares, a square root and two restoring divisions
// on one shared divider. A point that closes a loop carries two segments.
module polyline_quad_expander #(
  parameter int INDEX_BITS = pqe_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = pqe_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pqe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pqe_pkg::CFG_W-1:0]       cfg_data,
  pqe_pt_if.sink                          pt,
  pqe_rec_if.source                       rec
);

  // configuration registers
  logic [pqe_pkg::CFG_W-1:0] line_width;
  logic                      closed_loop;

  // job path between front and back
  pqe_pkg::job_t push_job, head_job;
  logic push_valid, push_ready, head_valid, job_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= pqe_pkg::LINE_WIDTH_RESET;
      closed_loop <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pqe_pkg::REG_LINE_WIDTH:  line_width  <= cfg_data;
        pqe_pkg::REG_CLOSED_LOOP: closed_loop <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: hold first and previous point, emit at most one job per cycle, holding it while the queue is full
  pqe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pt         (pt),
    .closed_loop(closed_loop),
    .push_job   (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  // queue: let the front advance while the back grinds on a segment
  pqe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (push_job),
    .push       (push_valid && push_ready),
    .push_ready (push_ready),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (job_pop)
  );

  // back: offset math, vertex and index records, bounds
  pqe_back #(
    .INDEX_BITS (INDEX_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job        (head_job),
    .job_valid  (head_valid),
    .job_pop    (job_pop),
    .line_width (line_width),
    .rec        (rec)
  );

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam int IDX_LIMIT = (1 << pqe_pkg::INDEX_BITS_DEF) - 1;
  // Longest quiet stretch of the back stage with nothing coming out: a few
  // skipped segments plus a full closing segment.
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               eol;
    logic               typed_empty;  // row whose expected record is typed in
  } point_t;

  typedef struct {
    pqe_pkg::rec_kind_t kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         corner;
    logic [23:0]        a;
    logic [23:0]        b;
    logic [23:0]        c;
    logic               last;
  } mesh_rec_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [pqe_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pqe_pkg::CFG_W-1:0] cfg_data;

  pqe_pt_if  pt_if ();
  pqe_rec_if rec_if ();

  polyline_quad_expander i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt        (pt_if),
    .rec       (rec_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("polyline_quad_expander verification failed");
    $finish;
  end

  // Mirror of the block's state, kept by the mesh predictor.
  logic [31:0]        mdl_width;
  logic               mdl_closed;
  logic signed [31:0] first_pt [3];
  logic signed [31:0] prev_pt [3];
  logic               have_prev;
  int unsigned        vert_count;
  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];

  mesh_rec_t mesh_q[$];
  int err_count = 0;
  int rec_count = 0;
  int pt_count = 0;
  int seg_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(CMAX)) return CMAX;
    if (v < longint'(CMIN)) return CMIN;
    return v[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= s) r = cand;
    end
    return r;
  endfunction

  function automatic void clear_line();
    have_prev = 1'b0;
    vert_count = 0;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = CMAX;
      box_hi[i] = CMIN;
    end
  endfunction

  function automatic void push_vertex(longint x, longint y, longint z, logic [1:0] c);
    mesh_rec_t r;
    r = '{pqe_pkg::REC_VERTEX, sat32(x), sat32(y), sat32(z), c, 0, 0, 0, 1'b0};
    if (r.x < box_lo[0]) box_lo[0] = r.x;
    if (r.y < box_lo[1]) box_lo[1] = r.y;
    if (r.z < box_lo[2]) box_lo[2] = r.z;
    if (r.x > box_hi[0]) box_hi[0] = r.x;
    if (r.y > box_hi[1]) box_hi[1] = r.y;
    if (r.z > box_hi[2]) box_hi[2] = r.z;
    mesh_q.push_back(r);
  endfunction

  // Expand one segment p0 -> p1 into four corners and two triangles.
  function automatic void expand_segment(logic signed [31:0] p0 [3],
                                         logic signed [31:0] p1 [3]);
    longint dx, dy, dz, ox, oy, x0, y0, z0, x1, y1, z1;
    longint unsigned ax, ay, az, mag, sq, len, mx, my, den;
    int unsigned base;
    x0 = p0[0]; y0 = p0[1]; z0 = p0[2];
    x1 = p1[0]; y1 = p1[1]; z1 = p1[2];
    dx = x1 - x0; dy = y1 - y0; dz = z1 - z0;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    mag = ax;
    if (ay > mag) mag = ay;
    if (az > mag) mag = az;
    // Skip a segment shorter than one millionth of a unit.
    if (mag < 256) begin
      sq = ax * ax + ay * ay + az * az;
      if (sq * 64'd1000000000000 < (64'd1 << (2 * pqe_pkg::FRAC_BITS_DEF))) return;
    end
    // Drop the segment once the vertex index space is used up.
    if (vert_count + 4 > IDX_LIMIT) return;
    while (mag < (64'd1 << 29)) begin
      ax <<= 1; ay <<= 1; az <<= 1; mag <<= 1;
    end
    while (mag >= (64'd1 << 31)) begin
      ax >>= 1; ay >>= 1; az >>= 1; mag >>= 1;
    end
    len = int_sqrt(ax * ax + ay * ay + az * az);
    den = 2 * len;
    mx = (longint'(mdl_width) * ay + den / 2) / den;
    my = (longint'(mdl_width) * ax + den / 2) / den;
    ox = dy < 0 ? longint'(mx) : -longint'(mx);
    oy = dx < 0 ? -longint'(my) : longint'(my);
    base = vert_count;
    push_vertex(x0 - ox, y0 - oy, z0, 2'd0);
    push_vertex(x0 + ox, y0 + oy, z0, 2'd1);
    push_vertex(x1 + ox, y1 + oy, z1, 2'd2);
    push_vertex(x1 - ox, y1 - oy, z1, 2'd3);
    mesh_q.push_back('{pqe_pkg::REC_TRI, 0, 0, 0, 2'd0, base, base + 1, base + 2, 1'b0});
    mesh_q.push_back('{pqe_pkg::REC_TRI, 0, 0, 0, 2'd0, base, base + 2, base + 3, 1'b0});
    vert_count = base + 4;
    seg_count++;
  endfunction

  // Work out the records one accepted point causes and queue them.
  function automatic void predict_point(point_t p);
    logic signed [31:0] cur [3];
    cur[0] = p.x; cur[1] = p.y; cur[2] = p.z;
    if (!have_prev) begin
      first_pt = cur;
      have_prev = 1'b1;
    end else begin
      expand_segment(prev_pt, cur);
    end
    prev_pt = cur;
    if (p.eol) begin
      if (mdl_closed) expand_segment(prev_pt, first_pt);
      if (vert_count == 0) begin
        mesh_q.push_back('{pqe_pkg::REC_EMPTY, 0, 0, 0, 2'd0, 0, 0, 0, 1'b1});
      end else begin
        mesh_q.push_back('{pqe_pkg::REC_BMIN, box_lo[0], box_lo[1], box_lo[2],
                           2'd0, 0, 0, 0, 1'b0});
        mesh_q.push_back('{pqe_pkg::REC_BMAX, box_hi[0], box_hi[1], box_hi[2],
                           2'd0, 0, 0, 0, 1'b1});
      end
      clear_line();
    end
  endfunction

  // Receiver: stall at random, check every record transaction.
  always @(posedge clk) begin
    mesh_rec_t e;
    if (rst) begin
      rec_if.ready <= 1'b0;
    end else begin
      rec_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (rec_if.valid && rec_if.ready) begin
        rec_count++;
        if (mesh_q.size() == 0) begin
          $error("unexpected record: kind %0d", rec_if.record_kind);
          err_count++;
        end else begin
          e = mesh_q.pop_front();
          if (rec_if.record_kind !== e.kind) begin
            $error("record_kind: expected %0d, got %0d", e.kind, rec_if.record_kind);
            err_count++;
          end
          if (rec_if.pos_x !== e.x) begin
            $error("pos_x: expected %0d, got %0d", e.x, rec_if.pos_x);
            err_count++;
          end
          if (rec_if.pos_y !== e.y) begin
            $error("pos_y: expected %0d, got %0d", e.y, rec_if.pos_y);
            err_count++;
          end
          if (rec_if.pos_z !== e.z) begin
            $error("pos_z: expected %0d, got %0d", e.z, rec_if.pos_z);
            err_count++;
          end
          if (rec_if.corner !== e.corner) begin
            $error("corner: expected %0d, got %0d", e.corner, rec_if.corner);
            err_count++;
          end
          if (rec_if.index_a !== e.a) begin
            $error("index_a: expected %0d, got %0d", e.a, rec_if.index_a);
            err_count++;
          end
          if (rec_if.index_b !== e.b) begin
            $error("index_b: expected %0d, got %0d", e.b, rec_if.index_b);
            err_count++;
          end
          if (rec_if.index_c !== e.c) begin
            $error("index_c: expected %0d, got %0d", e.c, rec_if.index_c);
            err_count++;
          end
          if (rec_if.last_record !== e.last) begin
            $error("last_record: expected %0d, got %0d", e.last, rec_if.last_record);
            err_count++;
          end
        end
      end
    end
  end

  // Drive one point and hold it until the block takes the transaction.
  task automatic send_point(point_t p);
    mesh_rec_t typed;
    pt_if.valid <= 1'b1;
    pt_if.point_x <= p.x;
    pt_if.point_y <= p.y;
    pt_if.point_z <= p.z;
    pt_if.end_of_line <= p.eol;
    do @(posedge clk); while (!pt_if.ready);
    pt_count++;
    if (p.typed_empty) begin
      // Advance the mirror, but expect the record typed in here.
      predict_point(p);
      void'(mesh_q.pop_back());
      typed = '{pqe_pkg::REC_EMPTY, 0, 0, 0, 2'd0, 0, 0, 0, 1'b1};
      mesh_q.push_back(typed);
    end else begin
      predict_point(p);
    end
    // Insert a gap after the transaction, if this phase idles the sender.
    if ($urandom_range(99) < send_idle_pct) begin
      pt_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic write_reg(logic [pqe_pkg::CFG_IDX_W-1:0] idx,
                           logic [pqe_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pqe_pkg::REG_LINE_WIDTH) mdl_width = val;
    else mdl_closed = val[0];
  endtask

  // Drop valid, wait for every expected record, then let the back stage go
  // quiet before the registers are touched.
  task automatic drain();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (mesh_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(logic signed [31:0] near);
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return near + $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
    if (sel < 75) return $urandom;
    if (sel < 85) return near;
    if (sel < 90) return near + $signed($urandom_range(2)) - 1;
    case ($urandom_range(2))
      0: return CMAX;
      1: return CMIN;
      default: return 32'sd0;
    endcase
  endfunction

  point_t dir_open [] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{32'sh0001_0000, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{32'sh0001_0000, 32'sh0001_0000, 32'sd0, 1'b0, 1'b0},
    '{32'sh0001_0000, 32'sh0001_0000, 32'sd0, 1'b0, 1'b0},
    '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0, 1'b0},
    '{CMAX, CMAX, CMAX, 1'b0, 1'b0},
    '{CMIN, CMIN, CMIN, 1'b0, 1'b0},
    '{CMIN, CMIN, CMIN, 1'b0, 1'b0},
    '{32'sd1, 32'sd1, 32'sd1, 1'b0, 1'b0},
    '{32'sd2, 32'sd1, 32'sd1, 1'b1, 1'b0},
    '{32'sd5, 32'sd5, 32'sd5, 1'b0, 1'b0},
    '{32'sd5, 32'sd5, 32'sd5, 1'b1, 1'b1}
  };

  point_t dir_closed [] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{32'sh0002_0000, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{32'sd0, 32'sh0002_0000, 32'sd5, 1'b1, 1'b0},
    '{32'sd7, 32'sd7, 32'sd7, 1'b1, 1'b1},
    '{CMIN, CMAX, 32'sd0, 1'b0, 1'b0},
    '{CMAX, CMIN, -32'sd1, 1'b1, 1'b0}
  };

  initial begin
    point_t p;
    logic signed [31:0] last_xyz [3];
    int len;
    int sent;
    int lines;
    logic [31:0] widths [6];
    int send_mix [6];
    int recv_mix [6];

    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    pt_if.valid <= 1'b0;
    pt_if.point_x <= '0;
    pt_if.point_y <= '0;
    pt_if.point_z <= '0;
    pt_if.end_of_line <= 1'b0;
    mdl_width = pqe_pkg::LINE_WIDTH_RESET;
    mdl_closed = 1'b0;
    first_pt = '{0, 0, 0};
    prev_pt = '{0, 0, 0};
    clear_line();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: open lines at reset settings, then closed lines at maximum width; extremes and degenerate segments.
    foreach (dir_open[i]) send_point(dir_open[i]);
    drain();
    write_reg(pqe_pkg::REG_LINE_WIDTH, 32'hFFFF_FFFF);
    write_reg(pqe_pkg::REG_CLOSED_LOOP, 1'b1);
    foreach (dir_closed[i]) send_point(dir_closed[i]);
    drain();

    // Random phases: well-formed polylines under changing width, loop mode, sender idling and receiver stalls.
    widths = '{32'd0, 32'd1, $urandom, 32'h0001_0000, 32'hFFFF_FFFF, $urandom_range(32'h0008_0000)};
    send_mix = '{0, 79, 0, 28, 0, 79};
    recv_mix = '{0, 0, 79, 28, 0, 79};
    lines = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(pqe_pkg::REG_LINE_WIDTH, widths[ph]);
      write_reg(pqe_pkg::REG_CLOSED_LOOP, ph % 2);
      send_idle_pct = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      sent = 0;
      last_xyz = '{$urandom, $urandom, $urandom};
      while (sent < 22) begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++) begin
          p.x = rand_coord(last_xyz[0]);
          p.y = rand_coord(last_xyz[1]);
          p.z = rand_coord(last_xyz[2]);
          p.eol = (k == len - 1);
          p.typed_empty = 1'b0;
          last_xyz = '{p.x, p.y, p.z};
          send_point(p);
          sent++;
        end
        lines++;
      end
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    $display("Sent %0d points in %0d random polylines plus directed rows.", pt_count, lines);
    $display("Checked %0d records from %0d emitted quads.", rec_count, seg_count);
    if (err_count == 0) begin
      $display("polyline_quad_expander verification clean");
    end else begin
      $display("polyline_quad_expander verification failed");
    end
    $finish;
  end

endmodule
